[rtl/ecbf_pkg.sv]
// ----------------------------------------------------------------------------
// Extremum chunk boundary finder package
// Register indexes, reset values, cut kinds and the fixed field widths shared by the
// channel interfaces and the chunker.
// ----------------------------------------------------------------------------
package ecbf_pkg;

  localparam int DATA_BYTE_W = 8;
  localparam int WINDOW_W    = 16;
  localparam int ROLL_CODE_W = 2;
  localparam int ROLL_W_BITS = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH   = 2'd0,
    CFG_FIND_MINIMUM    = 2'd1,
    CFG_ROLL_WIDTH_CODE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CUT_EXTREMUM  = 1'b0,
    CUT_REMAINDER = 1'b1
  } cut_kind_e;

  localparam logic [WINDOW_W-1:0]    WINDOW_RESET = 16'd3840;
  localparam logic [ROLL_CODE_W-1:0] ROLL_CODE_RESET = 2'd0;

endpackage

[rtl/ecbf_in_if.sv]
// ----------------------------------------------------------------------------
// Byte input channel
// One data byte per beat, with a flag on the last byte of a buffer.
// ----------------------------------------------------------------------------
interface ecbf_in_if;
  logic                             valid;
  logic                             ready;
  logic [ecbf_pkg::DATA_BYTE_W-1:0] data_byte;
  logic                             end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[rtl/ecbf_out_if.sv]
// ----------------------------------------------------------------------------
// Chunk result channel
// One closed chunk per beat: its length, how it was closed and a flag on the
// last beat caused by one input byte.
// ----------------------------------------------------------------------------
interface ecbf_out_if #(
  parameter int LENGTH_BITS = 24
);
  logic                   valid;
  logic                   ready;
  logic [LENGTH_BITS-1:0] chunk_length;
  logic                   cut_kind;
  logic                   run_end;

  modport source (output valid, output chunk_length, output cut_kind, output run_end,
                  input ready);
  modport sink   (input valid, input chunk_length, input cut_kind, input run_end,
                  output ready);
endinterface

[rtl/ecbf_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// One register write per beat: register index and write data.
// ----------------------------------------------------------------------------
interface ecbf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ecbf_pkg::CFG_IDX_W-1:0]  index;
  logic [ecbf_pkg::CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/extremum_chunk_boundary_finder.sv]
// ----------------------------------------------------------------------------
// Extremum chunk boundary finder
// Content-defined chunker using the asymmetric extremum rule over a stream of
// bytes, with a small result queue toward the output.
// ----------------------------------------------------------------------------
//
//   channel  dir  beat payload                              accepted when
//   -------  ---  ----------------------------------------  -----------------
//   in_i     in   data_byte, end_of_buffer                  valid && ready
//   out_o    out  chunk_length, cut_kind, run_end           valid && ready
//   cfg_i    in   index, wdata                              valid && ready
//
// One input byte is taken per cycle while the queue has room. The chunk
// state is updated in the cycle the byte is accepted, so the chunker itself
// never stalls; a byte's results are offered on out_o from the next cycle on.
// Results go into a four-entry queue; a byte is accepted while at most two
// entries are held, which leaves room for the two results a single byte can
// cause. Only back-pressure on out_o holds the input back. A cut landing on
// the last byte of a buffer (two output beats for one byte) is absorbed by the
// queue, since the byte after it opens a fresh chunk and adds at most one beat.
// rst_ni clears the chunk state, the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module extremum_chunk_boundary_finder #(
  parameter int LENGTH_BITS    = 24,
  parameter int MAX_ROLL_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ecbf_in_if.sink           in_i,
  ecbf_out_if.source        out_o,
  ecbf_cfg_if.sink          cfg_i
);

  // Width of the position value word and of the line of earlier bytes. The
  // line holds the bytes that precede the current one within a word.
  localparam int WordW     = 8 * MAX_ROLL_BYTES;
  localparam int LaDepth   = (MAX_ROLL_BYTES > 1) ? MAX_ROLL_BYTES - 1 : 1;
  localparam int LaIdxW    = (LaDepth > 1) ? $clog2(LaDepth) : 1;
  localparam int LenExtW   = LENGTH_BITS + 1;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = 2;
  localparam int FifoCntW  = 3;

  localparam logic [ecbf_pkg::ROLL_W_BITS-1:0] MaxRoll =
    ecbf_pkg::ROLL_W_BITS'(MAX_ROLL_BYTES);
  localparam logic [FifoCntW-1:0] FifoRoomLimit = FifoCntW'(FifoDepth - 2);

  typedef struct packed {
    logic [LENGTH_BITS-1:0] len;
    logic                   kind;
    logic                   last;
  } res_t;

  // Configuration registers.
  logic [ecbf_pkg::WINDOW_W-1:0]    window_q;
  logic                             find_min_q;
  logic [ecbf_pkg::ROLL_CODE_W-1:0] roll_code_q;

  // Chunk state.
  logic [LENGTH_BITS-1:0] pos_cnt_q, pos_cnt_d;
  logic [WordW-1:0]       ext_val_q, ext_val_d;
  logic [LENGTH_BITS-1:0] ext_pos_q, ext_pos_d;
  logic [7:0]             la_q [LaDepth];
  logic [7:0]             la_d [LaDepth];

  // Result queue.
  res_t                fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  // Datapath signals.
  logic                              in_fire, out_fire;
  logic [ecbf_pkg::ROLL_W_BITS-1:0]  roll_w;
  logic [WordW-1:0]                  word;
  logic                              live;
  logic [LENGTH_BITS-1:0]            pos_inc, wide_w, pos_p, rem_len;
  logic                              evaluate, beyond, win_hit, cut;
  res_t                              item0, item1;
  logic [1:0]                        push_n;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign in_i.ready  = (cnt_q <= FifoRoomLimit);
  assign cfg_i.ready = 1'b1;

  // Configuration writes. Writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= ecbf_pkg::WINDOW_RESET;
      find_min_q  <= 1'b0;
      roll_code_q <= ecbf_pkg::ROLL_CODE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (ecbf_pkg::cfg_idx_e'(cfg_i.index))
        ecbf_pkg::CFG_WINDOW_LENGTH:   window_q    <= cfg_i.wdata[ecbf_pkg::WINDOW_W-1:0];
        ecbf_pkg::CFG_FIND_MINIMUM:    find_min_q  <= cfg_i.wdata[0];
        ecbf_pkg::CFG_ROLL_WIDTH_CODE: roll_code_q <= cfg_i.wdata[ecbf_pkg::ROLL_CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Word width in bytes, clipped to the longest word the line can build.
  always_comb begin
    roll_w = ecbf_pkg::ROLL_W_BITS'(1) << roll_code_q;
    if (roll_w > MaxRoll) begin
      roll_w = MaxRoll;
    end
  end

  // The word of the position that completes with this byte. The new byte is
  // the most significant one; earlier bytes follow in order of age.
  always_comb begin
    word = '0;
    for (int j = 0; j < MAX_ROLL_BYTES; j++) begin
      if (j == int'(roll_w) - 1) begin
        word[8*j +: 8] = in_i.data_byte;
      end else if (j < int'(roll_w) - 1) begin
        word[8*j +: 8] = la_q[LaIdxW'(int'(roll_w) - 2 - j)];
      end
    end
  end

  // Position evaluation. The counter saturates at its all-ones value, and a
  // saturated chunk evaluates nothing more.
  assign live     = (pos_cnt_q != '1);
  assign pos_inc  = pos_cnt_q + 1'b1;
  assign wide_w   = LENGTH_BITS'(roll_w);
  assign evaluate = live && (pos_inc >= wide_w);
  assign pos_p    = pos_inc - wide_w;
  assign beyond   = find_min_q ? (word < ext_val_q) : (word > ext_val_q);
  assign win_hit  = ({1'b0, pos_p}) == ({1'b0, ext_pos_q} + LenExtW'(window_q));

  always_comb begin
    pos_cnt_d = pos_cnt_q;
    ext_val_d = ext_val_q;
    ext_pos_d = ext_pos_q;
    la_d      = la_q;
    cut       = 1'b0;
    rem_len   = '0;

    if (in_fire) begin
      if (live) begin
        pos_cnt_d = pos_inc;
      end
      if (evaluate) begin
        if (pos_p == '0) begin
          // First position of a chunk seeds the extremum.
          ext_val_d = word;
          ext_pos_d = '0;
        end else if (beyond) begin
          ext_val_d = word;
          ext_pos_d = pos_p;
        end else if (win_hit) begin
          // Cut before this position; it becomes position zero of the next
          // chunk, which already holds a full word of bytes.
          cut       = 1'b1;
          pos_cnt_d = wide_w;
          ext_val_d = word;
          ext_pos_d = '0;
        end
      end

      for (int k = LaDepth - 1; k > 0; k--) begin
        la_d[k] = la_q[k-1];
      end
      la_d[0] = in_i.data_byte;

      // The last byte closes whatever is left, then the stream restarts.
      rem_len = pos_cnt_d;
      if (in_i.end_of_buffer) begin
        pos_cnt_d = '0;
        ext_val_d = '0;
        ext_pos_d = '0;
        for (int k = 0; k < LaDepth; k++) begin
          la_d[k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_cnt_q <= '0;
      ext_val_q <= '0;
      ext_pos_q <= '0;
      for (int k = 0; k < LaDepth; k++) begin
        la_q[k] <= '0;
      end
    end else begin
      pos_cnt_q <= pos_cnt_d;
      ext_val_q <= ext_val_d;
      ext_pos_q <= ext_pos_d;
      la_q      <= la_d;
    end
  end

  // Results of this byte: an extremum cut first, the remainder second, and
  // the end-of-run flag on whichever comes last.
  always_comb begin
    item1.len  = rem_len;
    item1.kind = ecbf_pkg::CUT_REMAINDER;
    item1.last = 1'b1;
    if (cut) begin
      item0.len  = pos_p;
      item0.kind = ecbf_pkg::CUT_EXTREMUM;
      item0.last = !in_i.end_of_buffer;
    end else begin
      item0 = item1;
    end
    push_n = 2'd0;
    if (in_fire) begin
      push_n = {1'b0, cut} + {1'b0, in_i.end_of_buffer};
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= item0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + 1'b1] <= item1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FifoPtrW'(push_n);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + FifoCntW'(push_n) - FifoCntW'(out_fire);
    end
  end

  assign out_o.valid        = (cnt_q != '0);
  assign out_o.chunk_length = fifo_q[rd_ptr_q].len;
  assign out_o.cut_kind     = fifo_q[rd_ptr_q].kind;
  assign out_o.run_end      = fifo_q[rd_ptr_q].last;

endmodule
